### hdl/ir_code_pair_decompressor_defines.svh
// assertion macros shared by the decompressor modules
`ifndef IR_CODE_PAIR_DECOMPRESSOR_DEFINES_SVH
`define IR_CODE_PAIR_DECOMPRESSOR_DEFINES_SVH

// plain property checked on every clock, quiet during reset
`define ICPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ICPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	`ICPD_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ICPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	`ICPD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hdl/icpd_pkg.sv
// shared constants, types and helpers of the pair decompressor
package icpd_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int INDEX_W     = 4;
	localparam int IDX_EXT_W   = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
	localparam int TIME_W      = 15;
	localparam int ENTRY_W     = 2 * TIME_W;
	localparam int BYTE_BITS   = 8;
	localparam int COUNT_W     = 4;
	localparam int PBITS_W     = 3;
	localparam int PAIRS_W     = 8;
	localparam int MAX_WIDTH   = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_PERIOD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_COUNT     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_WIDTH    = 2'd2;

	localparam logic OP_CODE_BYTE = 1'b0;
	localparam logic OP_LOAD      = 1'b1;

	localparam logic [2:0] INDEX_WIDTH_RESET = 3'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FETCH,
		ST_FLUSH
	} icpd_state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic write_entry;
		logic load_byte;
		logic shift_bit;
		logic hold_load;
		logic flush;
	} icpd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_load;
		logic pair_count_zero;
		logic index_complete;
		logic last_bit;
		logic bits_done;
		logic out_free;
		logic hold_valid;
	} icpd_status_t;

	// width 0 acts as 1, above the maximum acts as the maximum
	function automatic logic [2:0] eff_width(input logic [2:0] w);
		logic [2:0] r;
		if (w == 3'd0)
			r = 3'd1;
		else if (w > 3'(MAX_WIDTH))
			r = 3'(MAX_WIDTH);
		else
			r = w;
		return r;
	endfunction

	function automatic logic [INDEX_W-1:0] index_mask(input logic [2:0] w);
		logic [INDEX_W-1:0] m;
		unique case (w)
			3'd1:    m = 4'b0001;
			3'd2:    m = 4'b0011;
			3'd3:    m = 4'b0111;
			default: m = 4'b1111;
		endcase
		return m;
	endfunction

endpackage

### hdl/icpd_if.sv
// valid/ready channel interfaces for code words and pair words
interface icpd_in_if;
	import icpd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [7:0]           code_byte;
	logic [INDEX_W-1:0]   entry_index;
	logic [TIME_W-1:0]    entry_on_time;
	logic [TIME_W-1:0]    entry_off_time;

	modport source (output valid, operation, code_byte, entry_index, entry_on_time,
		entry_off_time, input ready);
	modport sink (input valid, operation, code_byte, entry_index, entry_on_time,
		entry_off_time, output ready);
endinterface

interface icpd_out_if;
	import icpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] on_time;
	logic [TIME_W-1:0] off_time;
	logic              carrier_on;
	logic              code_done;
	logic              last;

	modport source (output valid, on_time, off_time, carrier_on, code_done, last,
		input ready);
	modport sink (input valid, on_time, off_time, carrier_on, code_done, last,
		output ready);
endinterface

### hdl/ir_code_pair_decompressor.sv
// top level of the infrared code pair decompressor
// usage
//   code_in carries one word per item: operation selects a table load
//   (entry_index, entry_on_time, entry_off_time) or a compressed code byte.
//   pair_out carries one on/off pair per complete table index, with
//   carrier_on, code_done on the final pair of a code and last on the final
//   pair caused by a code byte. the user must write carrier_period, pair_count
//   and index_width (cfg_we/cfg_index/cfg_data) only while idle; not enforced.
// timing
//   a load word is written to the table as it is accepted. a code byte is
//   accepted, then unpacked one bit per cycle in shift, pausing in fetch for
//   each complete index: its registered read from the single table read port,
//   held while hold and output are full. flush releases the final pair; a code
//   ending mid byte skips the rest. a pair waits in the hold register until
//   the next pair of its byte is fetched or the byte ends, so last is known.
// reset
//   arst_n clears the config registers to their defaults and empties the
//   unpacker and the output; the time table holds garbage until loaded.
// stalls
//   a pair waits in the output register while pair_out.ready is low; the
//   unpacker keeps one further pair in a hold register and pauses after it.
module ir_code_pair_decompressor
	import icpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	icpd_in_if.sink                code_in,
	icpd_out_if.source             pair_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// command and status between the controller and the datapath
	icpd_cmd_t    cmd;
	icpd_status_t status;

	// state machine: idle, shift one bit, fetch a table entry, release the last word
	icpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// config registers, bit unpacker, time table and output staging
	icpd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.code_in   (code_in),
		.pair_out  (pair_out),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

### hdl/icpd_ram.sv
// generic single-write, single-read ram with registered read data
module icpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

### hdl/icpd_ctrl.sv
// controller state machine of the pair decompressor
`include "ir_code_pair_decompressor_defines.svh"

module icpd_ctrl
	import icpd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  icpd_status_t status,
	output icpd_cmd_t    cmd
);

	icpd_state_t state_q;
	icpd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.in_valid && !status.in_load && !status.pair_count_zero)
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (status.index_complete)
					state_d = ST_FETCH;
				else if (status.last_bit)
					state_d = status.hold_valid ? ST_FLUSH : ST_IDLE;
			end
			ST_FETCH: begin
				if (!status.hold_valid || status.out_free)
					state_d = status.bits_done ? ST_FLUSH : ST_SHIFT;
			end
			ST_FLUSH: begin
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready    = 1'b1;
				cmd.write_entry = status.in_valid && status.in_load;
				cmd.load_byte   = status.in_valid && !status.in_load &&
					!status.pair_count_zero;
			end
			ST_SHIFT: begin
				cmd.shift_bit = 1'b1;
			end
			ST_FETCH: begin
				cmd.hold_load = !status.hold_valid || status.out_free;
			end
			ST_FLUSH: begin
				cmd.flush = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

	`ICPD_ASSERT_IMPL(a_fetch_after_shift, state_q == ST_FETCH, $past(state_q) == ST_SHIFT || $past(state_q) == ST_FETCH, "fetch entered without a completed index")
	`ICPD_ASSERT_IMPL(a_flush_has_word, state_q == ST_FLUSH, status.hold_valid, "flush with no held word")
	`ICPD_ASSERT_IMPL(a_idle_hold_empty, state_q == ST_IDLE, !status.hold_valid, "held word left over after a byte")

endmodule

### hdl/icpd_datapath.sv
// datapath: config registers, bit unpacker, time table, hold and output registers
`include "ir_code_pair_decompressor_defines.svh"

module icpd_datapath
	import icpd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	icpd_in_if.sink       code_in,
	icpd_out_if.source    pair_out,
	input  icpd_cmd_t     cmd,
	output icpd_status_t  status
);

	// configuration
	logic [7:0] carrier_period_q;
	logic [7:0] pair_count_q;
	logic [2:0] index_width_q;

	// unpacker state
	logic [BYTE_BITS-1:0] shift_q;
	logic [COUNT_W-1:0]   bits_left_q;
	logic [INDEX_W-1:0]   partial_index_q;
	logic [PBITS_W-1:0]   partial_bits_q;
	logic [PAIRS_W-1:0]   pairs_q;

	// read side metadata, registered alongside the table read data
	logic beyond_s1;
	logic done_s1;

	// held word waiting to learn whether it is the last of its byte
	logic              hold_valid_q;
	logic [TIME_W-1:0] hold_on_q;
	logic [TIME_W-1:0] hold_off_q;
	logic              hold_carrier_q;
	logic              hold_done_q;

	// output register
	logic              out_valid_q;
	logic [TIME_W-1:0] out_on_q;
	logic [TIME_W-1:0] out_off_q;
	logic              out_carrier_q;
	logic              out_done_q;
	logic              out_last_q;

	logic [2:0]           width;
	logic [INDEX_W-1:0]   partial_next;
	logic [PBITS_W-1:0]   pbits_next;
	logic                 index_complete;
	logic [INDEX_W-1:0]   index_val;
	logic [IDX_EXT_W-1:0] rd_ext;
	logic [IDX_EXT_W-1:0] wr_ext;
	logic                 rd_beyond;
	logic                 wr_inside;
	logic [PAIRS_W-1:0]   pairs_next;
	logic                 done_now;
	logic                 read_en;
	logic                 write_en;
	logic [ENTRY_W-1:0]   rd_data;
	logic                 out_free;
	logic                 out_push;

	assign width          = eff_width(index_width_q);
	assign partial_next   = {partial_index_q[INDEX_W-2:0], shift_q[BYTE_BITS-1]};
	assign pbits_next     = partial_bits_q + 3'd1;
	assign index_complete = pbits_next >= width;
	assign index_val      = partial_next & index_mask(width);
	assign rd_ext         = IDX_EXT_W'(index_val);
	assign wr_ext         = IDX_EXT_W'(code_in.entry_index);
	assign rd_beyond      = int'(rd_ext) >= TABLE_DEPTH;
	assign wr_inside      = int'(wr_ext) < TABLE_DEPTH;
	assign pairs_next     = pairs_q + 8'd1;
	assign done_now       = (pairs_next >= pair_count_q) || (pairs_next == 8'd0);
	assign read_en        = cmd.shift_bit && index_complete;
	assign write_en       = cmd.write_entry && wr_inside;
	assign out_free       = !out_valid_q || pair_out.ready;
	assign out_push       = (cmd.hold_load && hold_valid_q) || cmd.flush;

	icpd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (write_en),
		.waddr (wr_ext[ADDR_W-1:0]),
		.wdata ({code_in.entry_on_time, code_in.entry_off_time}),
		.re    (read_en),
		.raddr (rd_ext[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_period_q <= 8'd0;
			pair_count_q     <= 8'd0;
			index_width_q    <= INDEX_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CARRIER_PERIOD: carrier_period_q <= cfg_data;
				CFG_PAIR_COUNT:     pair_count_q     <= cfg_data;
				CFG_INDEX_WIDTH:    index_width_q    <= cfg_data[2:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q         <= '0;
			bits_left_q     <= '0;
			partial_index_q <= '0;
			partial_bits_q  <= '0;
			pairs_q         <= '0;
		end else if (cmd.load_byte) begin
			shift_q     <= code_in.code_byte;
			bits_left_q <= COUNT_W'(BYTE_BITS);
		end else if (cmd.shift_bit) begin
			shift_q <= {shift_q[BYTE_BITS-2:0], 1'b0};
			if (index_complete) begin
				partial_index_q <= '0;
				partial_bits_q  <= '0;
				if (done_now) begin
					bits_left_q <= '0;
					pairs_q     <= '0;
				end else begin
					bits_left_q <= bits_left_q - 4'd1;
					pairs_q     <= pairs_next;
				end
			end else begin
				partial_index_q <= partial_next;
				partial_bits_q  <= pbits_next;
				bits_left_q     <= bits_left_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_en) begin
			beyond_s1 <= rd_beyond;
			done_s1   <= done_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_valid_q <= 1'b0;
		else if (cmd.hold_load)
			hold_valid_q <= 1'b1;
		else if (cmd.flush)
			hold_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_load) begin
			hold_on_q      <= beyond_s1 ? '0 : rd_data[ENTRY_W-1:TIME_W];
			hold_off_q     <= beyond_s1 ? '0 : rd_data[TIME_W-1:0];
			hold_carrier_q <= carrier_period_q != 8'd0;
			hold_done_q    <= done_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_push)
			out_valid_q <= 1'b1;
		else if (pair_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_on_q      <= hold_on_q;
			out_off_q     <= hold_off_q;
			out_carrier_q <= hold_carrier_q;
			out_done_q    <= hold_done_q;
			out_last_q    <= cmd.flush;
		end
	end

	assign code_in.ready       = cmd.in_ready;
	assign pair_out.valid      = out_valid_q;
	assign pair_out.on_time    = out_on_q;
	assign pair_out.off_time   = out_off_q;
	assign pair_out.carrier_on = out_carrier_q;
	assign pair_out.code_done  = out_done_q;
	assign pair_out.last       = out_last_q;

	assign status.in_valid        = code_in.valid;
	assign status.in_load         = code_in.operation == OP_LOAD;
	assign status.pair_count_zero = pair_count_q == 8'd0;
	assign status.index_complete  = index_complete;
	assign status.last_bit        = bits_left_q == 4'd1;
	assign status.bits_done       = bits_left_q == 4'd0;
	assign status.out_free        = out_free;
	assign status.hold_valid      = hold_valid_q;

	`ICPD_ASSERT_IMPL(a_push_needs_room, out_push, out_free, "word pushed over an untaken output word")
	`ICPD_ASSERT_NEXT(a_code_end_clears, read_en && done_now, pairs_q == 8'd0 && bits_left_q == 4'd0, "code end did not clear counters")
	`ICPD_ASSERT(a_partial_bounded, partial_bits_q < 3'(MAX_WIDTH), "partial index holds too many bits")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the infrared code pair decompressor
module testbench;
	import icpd_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_WORDS  = 310;
	localparam int SETTLE_CYCLES = 24;
	localparam int CALM_TAIL     = 40;
	localparam int REPORT_LIMIT  = 10;

	// one word on the code channel
	typedef struct packed {
		logic               operation;
		logic [7:0]         code_byte;
		logic [INDEX_W-1:0] entry_index;
		logic [TIME_W-1:0]  entry_on_time;
		logic [TIME_W-1:0]  entry_off_time;
	} code_word_t;

	// one word on the pair channel
	typedef struct packed {
		logic [TIME_W-1:0] on_time;
		logic [TIME_W-1:0] off_time;
		logic              carrier_on;
		logic              code_done;
		logic              last;
	} pair_word_t;

	// mirrors the unpacker and the time table, queues the pairs each word must yield
	class pair_tracker;
		pair_word_t         pending_pairs[$];
		logic [7:0]         carrier_period;
		logic [7:0]         pair_count;
		logic [2:0]         index_width;
		logic [INDEX_W-1:0] partial_index;
		logic [2:0]         partial_bits;
		logic [7:0]         pairs_emitted;
		logic [ENTRY_W-1:0] time_table[TABLE_DEPTH];
		int                 mismatches;
		int                 pairs_checked;
		int                 loads_seen;
		int                 bytes_seen;

		function new();
			carrier_period = '0;
			pair_count     = '0;
			index_width    = INDEX_WIDTH_RESET;
			partial_index  = '0;
			partial_bits   = '0;
			pairs_emitted  = '0;
			mismatches     = 0;
			pairs_checked  = 0;
			loads_seen     = 0;
			bytes_seen     = 0;
		endfunction

		function void write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
			case (idx)
				CFG_CARRIER_PERIOD: carrier_period = data;
				CFG_PAIR_COUNT:     pair_count = data;
				CFG_INDEX_WIDTH:    index_width = data[2:0];
				default: ;
			endcase
		endfunction

		// zero acts as one bit, anything past the maximum as the maximum
		function logic [2:0] active_width();
			if (index_width == 3'd0)
				return 3'd1;
			if (index_width > 3'(MAX_WIDTH))
				return 3'(MAX_WIDTH);
			return index_width;
		endfunction

		function void absorb_word(input code_word_t w);
			logic [2:0]         width;
			logic [INDEX_W-1:0] idx;
			logic [ENTRY_W-1:0] entry;
			pair_word_t         p;
			pair_word_t         held;
			bit                 have_held;
			have_held = 1'b0;
			if (w.operation == OP_LOAD) begin
				loads_seen++;
				time_table[w.entry_index] = {w.entry_on_time, w.entry_off_time};
				return;
			end
			bytes_seen++;
			if (pair_count == 8'd0)
				return;
			width = active_width();
			for (int b = BYTE_BITS - 1; b >= 0; b--) begin
				partial_index = {partial_index[INDEX_W-2:0], w.code_byte[b]};
				partial_bits  = partial_bits + 3'd1;
				if (partial_bits < width)
					continue;
				idx = partial_index & ~(4'hF << width);
				entry = time_table[idx];
				partial_index = '0;
				partial_bits  = '0;
				pairs_emitted = pairs_emitted + 8'd1;
				p.on_time    = entry[ENTRY_W-1:TIME_W];
				p.off_time   = entry[TIME_W-1:0];
				p.carrier_on = (carrier_period != 8'd0);
				p.code_done  = (pairs_emitted >= pair_count) || (pairs_emitted == 8'd0);
				p.last       = 1'b0;
				// hold back one pair so the final one of this byte can be marked
				if (have_held)
					pending_pairs.push_back(held);
				held = p;
				have_held = 1'b1;
				if (p.code_done) begin
					pairs_emitted = '0;
					break;
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				pending_pairs.push_back(held);
			end
		endfunction

		function void match_pair(input pair_word_t got);
			pair_word_t want;
			if (pending_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("pair with none expected: on %0d off %0d carrier %0b done %0b last %0b",
						got.on_time, got.off_time, got.carrier_on, got.code_done, got.last);
				return;
			end
			want = pending_pairs.pop_front();
			pairs_checked++;
			if (got.on_time !== want.on_time || got.off_time !== want.off_time ||
					got.carrier_on !== want.carrier_on || got.code_done !== want.code_done ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("pair %0d expected: on %0d off %0d carrier %0b done %0b last %0b",
						pairs_checked, want.on_time, want.off_time, want.carrier_on,
						want.code_done, want.last);
					$display("pair %0d actual:   on %0d off %0d carrier %0b done %0b last %0b",
						pairs_checked, got.on_time, got.off_time, got.carrier_on,
						got.code_done, got.last);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	icpd_in_if  code_if();
	icpd_out_if pair_if();

	pair_tracker tracker;
	pair_word_t  seen_pair;

	// idling controls: off for the tail, and per phase each side may run calm
	bit idling_on;
	bit sender_calm;
	bit receiver_calm;
	int stall_left;
	int cycle_count;
	int reg_writes;
	int sender_pauses;

	ir_code_pair_decompressor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_in   (code_if),
		.pair_out  (pair_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// watchdog: a lost pair or a stuck handshake ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs still expected", cycle_count,
				tracker.pending_pairs.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// pair receiver: stalls come in random bursts unless idling is off or it runs calm
	always @(posedge clk) begin
		if (stall_left > 0) begin
			pair_if.ready <= 1'b0;
			stall_left--;
		end else if (idling_on && !receiver_calm && $urandom_range(0, 5) == 0) begin
			pair_if.ready <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end else begin
			pair_if.ready <= 1'b1;
		end
	end

	// pair monitor: values read here are the ones present at the edge
	always @(posedge clk) begin
		if (arst_n && pair_if.valid && pair_if.ready) begin
			seen_pair = {pair_if.on_time, pair_if.off_time, pair_if.carrier_on,
				pair_if.code_done, pair_if.last};
			tracker.match_pair(seen_pair);
		end
	end

	function automatic code_word_t make_load(input logic [INDEX_W-1:0] idx,
			input logic [TIME_W-1:0] on_t, input logic [TIME_W-1:0] off_t);
		code_word_t w;
		w.operation      = OP_LOAD;
		w.code_byte      = 8'($urandom);
		w.entry_index    = idx;
		w.entry_on_time  = on_t;
		w.entry_off_time = off_t;
		return w;
	endfunction

	// entry fields ride along with random content, the block ignores them
	function automatic code_word_t make_byte(input logic [7:0] b);
		code_word_t w;
		w.operation      = OP_CODE_BYTE;
		w.code_byte      = b;
		w.entry_index    = INDEX_W'($urandom);
		w.entry_on_time  = TIME_W'($urandom);
		w.entry_off_time = TIME_W'($urandom);
		return w;
	endfunction

	// offer one word, hold it until taken; valid stays up for the next word
	task automatic send_word(input code_word_t w);
		if (idling_on && !sender_calm && $urandom_range(0, 3) == 0) begin
			code_if.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		code_if.valid          <= 1'b1;
		code_if.operation      <= w.operation;
		code_if.code_byte      <= w.code_byte;
		code_if.entry_index    <= w.entry_index;
		code_if.entry_on_time  <= w.entry_on_time;
		code_if.entry_off_time <= w.entry_off_time;
		@(posedge clk);
		while (!code_if.ready)
			@(posedge clk);
		tracker.absorb_word(w);
	endtask

	// stop sending until every pair is back, then let a byte with no pairs settle
	task automatic drain_pairs();
		code_if.valid <= 1'b0;
		sender_pauses++;
		while (tracker.pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_one(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
		reg_writes++;
	endtask

	// which[0] carrier period, which[1] pair count, which[2] index width
	task automatic program_regs(input bit [2:0] which, input logic [7:0] period,
			input logic [7:0] count, input logic [7:0] width_data);
		if (which[0])
			write_one(CFG_CARRIER_PERIOD, period);
		if (which[1])
			write_one(CFG_PAIR_COUNT, count);
		if (which[2])
			write_one(CFG_INDEX_WIDTH, width_data);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [TIME_W-1:0] on_t;
		logic [TIME_W-1:0] off_t;
		logic [7:0]        period;
		logic [7:0]        count;
		logic [7:0]        width_data;
		bit [2:0]          which;
		int                counted;
		int                phase;
		int                phase_len;
		code_word_t        w;

		// every input known from time zero
		tracker       = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		code_if.valid = 1'b0;
		code_if.operation      = OP_CODE_BYTE;
		code_if.code_byte      = '0;
		code_if.entry_index    = '0;
		code_if.entry_on_time  = '0;
		code_if.entry_off_time = '0;
		pair_if.ready = 1'b0;
		idling_on     = 1'b1;
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		stall_left    = 0;
		cycle_count   = 0;
		reg_writes    = 0;
		sender_pauses = 0;
		counted       = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pair count is zero out of reset: this byte must be dropped silently
		send_word(make_byte(8'hFF));

		// fill the whole table so no unwritten entry is ever read;
		// entry 0 and entry 15 carry the time extremes
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			on_t  = (i == 0) ? '0 : (i == TABLE_DEPTH - 1) ? '1 : TIME_W'($urandom);
			off_t = (i == 0) ? '1 : (i == TABLE_DEPTH - 1) ? '0 : TIME_W'($urandom);
			send_word(make_load(INDEX_W'(i), on_t, off_t));
		end
		drain_pairs();

		// index width left at its reset value; code ends mid byte, leftover dropped
		program_regs(3'b011, 8'd0, 8'd3, 8'd0);
		send_word(make_byte(8'hFF));
		drain_pairs();

		// three-bit indices leave two bits waiting across the byte boundary
		program_regs(3'b111, 8'd255, 8'd100, 8'd3);
		send_word(make_byte(8'h00));
		drain_pairs();

		// width lowered while an index is half built: it completes on the next bit
		program_regs(3'b100, 8'd0, 8'd0, 8'd1);
		send_word(make_byte(8'hA5));
		send_word(make_byte(8'h5A));
		drain_pairs();

		// width zero acts as one bit, width seven as four
		program_regs(3'b100, 8'd0, 8'd0, 8'd0);
		send_word(make_byte(8'h96));
		drain_pairs();
		program_regs(3'b100, 8'd0, 8'd0, 8'hFF);
		send_word(make_byte(8'h3C));
		drain_pairs();

		// pair count lowered below the pairs already sent: next pair ends the code
		program_regs(3'b010, 8'd0, 8'd2, 8'd0);
		send_word(make_byte(8'h81));
		drain_pairs();

		// one-pair codes at full width
		program_regs(3'b111, 8'd1, 8'd1, 8'd4);
		send_word(make_byte(8'hE7));

		// random phases; the first one sets up a 255-pair code at one-bit indices
		phase = 0;
		while (counted < RANDOM_WORDS) begin
			drain_pairs();
			if (phase == 0) begin
				which      = 3'b111;
				period     = 8'($urandom_range(1, 254));
				count      = 8'd255;
				width_data = 8'd1;
				phase_len  = 36;
			end else begin
				which = 3'($urandom_range(1, 7));
				case ($urandom_range(0, 3))
					0:       period = 8'd0;
					1:       period = 8'd255;
					default: period = 8'($urandom_range(1, 254));
				endcase
				case ($urandom_range(0, 11))
					0:       count = 8'd0;
					1:       count = 8'd1;
					2:       count = 8'd255;
					3:       count = 8'($urandom_range(100, 254));
					default: count = 8'($urandom_range(2, 24));
				endcase
				// upper data bits are junk the register must drop
				width_data = {5'($urandom), 3'($urandom_range(0, 7))};
				phase_len  = $urandom_range(6, 30);
			end
			program_regs(which, period, count, width_data);
			sender_calm   = ($urandom_range(0, 3) == 0);
			receiver_calm = ($urandom_range(0, 3) == 0);

			repeat (phase_len) begin
				idling_on = (counted < RANDOM_WORDS - CALM_TAIL);
				if ($urandom_range(0, 6) == 0)
					w = make_load(INDEX_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
				else
					w = make_byte(8'($urandom));
				send_word(w);
				// bytes dropped for a zero pair count do not count toward the total
				if (w.operation == OP_LOAD || tracker.pair_count != 8'd0)
					counted++;
			end
			phase++;
		end

		code_if.valid <= 1'b0;
		while (tracker.pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d table loads and %0d code bytes over %0d phases, %0d register writes",
			tracker.loads_seen, tracker.bytes_seen, phase, reg_writes);
		$display("compared %0d pairs, %0d mismatched, %0d full drains, %0d cycles",
			tracker.pairs_checked, tracker.mismatches, sender_pauses, cycle_count);
		if (tracker.mismatches == 0 && tracker.pending_pairs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
